// ===== sv/lgt_pkg.sv =====
// Shared constants for the toroidal life grid unit.
`timescale 1ns / 1ps

package lgt_pkg;

    // Default grid size.
    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 32;

    // Fixed widths of the request fields.
    localparam int CMD_W = 2;
    localparam int ROW_W = 4;
    localparam int COL_W = 5;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    // Life rule neighbor counts.
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] STAY_COUNT  = 4'd2;

endpackage

// ===== sv/lgt_grid_mem.sv =====
// Grid store: one row per word, registered read, per-row valid bits.
`timescale 1ns / 1ps

module lgt_grid_mem
    import lgt_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF,
    localparam int RW = $clog2(ROWS)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [RW-1:0]   rd_addr,
    output logic [COLS-1:0] rd_data,
    input  logic            wr_en,
    input  logic [RW-1:0]   wr_addr,
    input  logic [COLS-1:0] wr_data
);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] q_reg;
    logic [ROWS-1:0] row_valid_reg;
    logic            q_valid_reg;

    // Row data has no reset; a row never written reads as all dead.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            q_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

// ===== sv/lgt_row_rule.sv =====
// Next-generation value of one grid row from its old row and both neighbor rows.
`timescale 1ns / 1ps

module lgt_row_rule
    import lgt_pkg::*;
#(
    parameter int COLS = COLS_DEF
)
(
    input  logic [COLS-1:0] up,
    input  logic [COLS-1:0] mid,
    input  logic [COLS-1:0] down,
    output logic [COLS-1:0] nxt
);

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        localparam int L = (c + COLS - 1) % COLS;
        localparam int R = (c + 1) % COLS;
        logic [3:0] cnt;

        assign cnt = 4'(up[L]) + 4'(up[c]) + 4'(up[R])
                   + 4'(mid[L]) + 4'(mid[R])
                   + 4'(down[L]) + 4'(down[c]) + 4'(down[R]);

        assign nxt[c] = (cnt == BIRTH_COUNT) || (mid[c] && (cnt == STAY_COUNT));
    end

endmodule

// ===== sv/life_generation_toroidal_unit.sv =====
// Top level of the toroidal life grid unit: request sequencer and result register.
`timescale 1ns / 1ps

//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid, in_stall, cmd, row, col,        | in
//          | alive_in                                  |
//  result  | out_valid, out_stall, alive_out, done_res | out
//
// A cell write or read reads the row word from the grid memory when it is accepted,
// then modifies and writes it back and loads the result in state S_CELL.
// An advance fetches the last row, row 0 and row 1 first, in states S_IDLE,
// S_G_LAST and S_G_ROW0, then one row is computed and written back per cycle,
// bounded by the single read port of the grid memory. Reset clears all control
// state and marks every grid row invalid, so the whole grid reads as dead at
// once. The request side stalls while a request is in progress and while a
// finished result is held by a stalled result side.

module life_generation_toroidal_unit
    import lgt_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] cmd,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    input  logic             alive_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             alive_out,
    output logic             done_res
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CELL   = 3'd1;
    localparam logic [2:0] S_G_LAST = 3'd2;
    localparam logic [2:0] S_G_ROW0 = 3'd3;
    localparam logic [2:0] S_G_STEP = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [RW-1:0]    r_reg, r_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic             val_reg, val_next;
    logic [COLS-1:0]  up_reg, up_next;
    logic [COLS-1:0]  cur_reg, cur_next;
    logic [COLS-1:0]  row0_reg, row0_next;
    logic             out_valid_reg, out_valid_next;
    logic             alive_out_reg, alive_out_next;
    logic             done_res_reg, done_res_next;

    logic            accept;
    logic            on_grid;
    logic            last_row;
    logic [RW:0]     ahead;
    logic            mem_rd_en;
    logic [RW-1:0]   mem_rd_addr;
    logic [COLS-1:0] mem_rd_data;
    logic            mem_wr_en;
    logic [RW-1:0]   mem_wr_addr;
    logic [COLS-1:0] mem_wr_data;
    logic [COLS-1:0] down_row;
    logic [COLS-1:0] new_row;
    logic [COLS-1:0] bit_mask;
    logic            cell_bit;

    lgt_grid_mem #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    lgt_row_rule #(
        .COLS (COLS)
    ) u_rule (
        .up   (up_reg),
        .mid  (cur_reg),
        .down (down_row),
        .nxt  (new_row)
    );

    // Only one request is in flight, so the result register is always free by
    // the time the request finishes if it was free when the request came in.
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign on_grid  = (int'(row) < ROWS) && (int'(col) < COLS);

    // During an advance the row below the last row is the old row 0, which
    // was saved before row 0 was overwritten.
    assign last_row = (r_reg == RW'(ROWS - 1));
    assign ahead    = {1'b0, r_reg} + (RW+1)'(2);
    assign down_row = last_row ? row0_reg : mem_rd_data;

    assign bit_mask = COLS'(1) << col_reg;
    assign cell_bit = |(mem_rd_data & bit_mask);

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        col_next       = col_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        up_next        = up_reg;
        cur_next       = cur_reg;
        row0_next      = row0_reg;
        out_valid_next = out_valid_reg && out_stall;
        alive_out_next = alive_out_reg;
        done_res_next  = done_res_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = r_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = r_reg;
        mem_wr_data    = mem_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    r_next   = RW'(row);
                    col_next = CW'(col);
                    val_next = alive_in;
                    case (cmd)
                        CMD_WRITE, CMD_READ:
                        begin
                            if (on_grid)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = RW'(row);
                                state_next  = S_CELL;
                            end
                            else
                            begin
                                // A cell outside the grid completes at once.
                                out_valid_next = 1'b1;
                                alive_out_next = 1'b0;
                                done_res_next  = 1'b1;
                            end
                        end
                        CMD_ADVANCE:
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = RW'(ROWS - 1);
                            state_next  = S_G_LAST;
                        end
                        default:
                        begin
                            // The unused code completes with done_res low.
                            out_valid_next = 1'b1;
                            alive_out_next = 1'b0;
                            done_res_next  = 1'b0;
                        end
                    endcase
                end
            end
            S_CELL:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = val_reg ? (mem_rd_data | bit_mask)
                                          : (mem_rd_data & ~bit_mask);
                end
                out_valid_next = 1'b1;
                alive_out_next = (cmd_reg == CMD_READ) && cell_bit;
                done_res_next  = 1'b1;
                state_next     = S_IDLE;
            end
            S_G_LAST:
            begin
                up_next     = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_next  = S_G_ROW0;
            end
            S_G_ROW0:
            begin
                cur_next    = mem_rd_data;
                row0_next   = mem_rd_data;
                r_next      = '0;
                mem_rd_en   = 1'b1;
                mem_rd_addr = RW'(1);
                state_next  = S_G_STEP;
            end
            S_G_STEP:
            begin
                // Row r is rewritten in place; its old value moves to up_reg.
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_reg;
                mem_wr_data = new_row;
                up_next     = cur_reg;
                cur_next    = down_row;
                if (ahead < (RW+1)'(ROWS))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ahead[RW-1:0];
                end
                if (last_row)
                begin
                    out_valid_next = 1'b1;
                    alive_out_next = 1'b0;
                    done_res_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    r_next = r_reg + RW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        col_reg       <= col_next;
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        up_reg        <= up_next;
        cur_reg       <= cur_next;
        row0_reg      <= row0_next;
        alive_out_reg <= alive_out_next;
        done_res_reg  <= done_res_next;
    end

    assign out_valid = out_valid_reg;
    assign alive_out = alive_out_reg;
    assign done_res  = done_res_reg;

endmodule
